### hw/rtl/gpi_pkg.sv
// Shared types, codes and field arithmetic for the GF(2^8) unit.
`timescale 1ns / 1ps

package gpi_pkg;

  localparam int NUM_STAGES = 8;

  localparam logic [7:0] REDUCE_LOW  = 8'h1B;
  localparam logic [7:0] INV_EXP     = 8'hFE;
  localparam logic [7:0] FIELD_ONE   = 8'h01;
  localparam logic [7:0] FIELD_ZERO  = 8'h00;

  localparam logic [1:0] MODE_MUL = 2'd0;
  localparam logic [1:0] MODE_POW = 2'd1;
  localparam logic [1:0] MODE_INV = 2'd2;

  // Running state of one square-and-multiply item.
  typedef struct packed {
    logic [7:0] acc;
    logic [7:0] base;
    logic [7:0] expo;   // remaining exponent bits, consumed from bit 0
  } word_t;

  // Carry-less product reduced by x^8+x^4+x^3+x+1.
  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] acc;
    logic [7:0] sh;
    acc = FIELD_ZERO;
    sh  = a;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) begin
        acc = acc ^ sh;
      end
      sh = {sh[6:0], 1'b0} ^ (sh[7] ? REDUCE_LOW : FIELD_ZERO);
    end
    return acc;
  endfunction

endpackage

### hw/rtl/gpi_sqmul.sv
// One square-and-multiply pipeline stage with its own register and valid bit.
`timescale 1ns / 1ps

module gpi_sqmul (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  gpi_pkg::word_t in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output gpi_pkg::word_t out_data
);

  logic           valid;
  gpi_pkg::word_t data;
  gpi_pkg::word_t data_next;

  assign in_ready = !valid || out_ready;

  always_comb begin
    data_next.acc  = in_data.expo[0] ? gpi_pkg::gf_mul(in_data.acc, in_data.base)
                                     : in_data.acc;
    data_next.base = gpi_pkg::gf_mul(in_data.base, in_data.base);
    data_next.expo = {1'b0, in_data.expo[7:1]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      data <= data_next;
    end
  end

  assign out_valid = valid;
  assign out_data  = data;

endmodule

### hw/rtl/gf256_mul_pow_inv.sv
// Top level: pipelined GF(2^8) multiply, power and inverse unit.
`timescale 1ns / 1ps
//
// Usage:
//  - Input stream s_axis_*: one transfer carries mode, operand_a, operand_b.
//    Mode 0 multiplies a*b, mode 1 raises a to b, mode 2 inverts a (a^254,
//    zero stays zero). Mode 3 returns 0.
//  - Output stream m_axis_*: one transfer per input, in input order.
//  - Path: an input transfer passes one decode register and then eight
//    square-and-multiply stages before it shows on tvalid.
//  - Throughput: one item per cycle unless the receiver stalls; each stage
//    handles one exponent bit with its own pair of GF multipliers.
//  - Every stage has its own valid bit and a per-stage ready, so bubbles
//    collapse: while the receiver stalls, the input keeps taking items
//    until every stage is full, then tready drops. Nothing is lost or
//    repeated.
//  - Reset (rst, synchronous) clears all valid bits; data is not cleared.
//  - Multiply runs through the same stages: acc starts at a, base at b,
//    exponent 1, so the first stage forms a*b and the rest pass it along.

module gf256_mul_pow_inv (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // [1:0] mode, [9:2] operand_a, [17:10] operand_b
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata    // [7:0] field_result
);

  localparam int NS = gpi_pkg::NUM_STAGES;

  logic [1:0] mode;
  logic [7:0] operand_a;
  logic [7:0] operand_b;

  assign mode      = s_axis_tdata[1:0];
  assign operand_a = s_axis_tdata[9:2];
  assign operand_b = s_axis_tdata[17:10];

  // Decode register
  logic           dec_valid;
  logic           dec_ready;
  gpi_pkg::word_t dec_data;
  gpi_pkg::word_t dec_next;

  always_comb begin
    case (mode)
      gpi_pkg::MODE_MUL: begin
        dec_next.acc  = operand_a;
        dec_next.base = operand_b;
        dec_next.expo = gpi_pkg::FIELD_ONE;
      end
      gpi_pkg::MODE_POW: begin
        dec_next.acc  = gpi_pkg::FIELD_ONE;
        dec_next.base = operand_a;
        dec_next.expo = operand_b;
      end
      gpi_pkg::MODE_INV: begin
        dec_next.acc  = gpi_pkg::FIELD_ONE;
        dec_next.base = operand_a;
        dec_next.expo = gpi_pkg::INV_EXP;
      end
      default: begin
        // unused code: zero accumulator and exponent, so acc stays zero
        dec_next.acc  = gpi_pkg::FIELD_ZERO;
        dec_next.base = operand_a;
        dec_next.expo = gpi_pkg::FIELD_ZERO;
      end
    endcase
  end

  assign s_axis_tready = !dec_valid || dec_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      dec_valid <= 1'b0;
    end else if (s_axis_tready) begin
      dec_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      dec_data <= dec_next;
    end
  end

  // Square-and-multiply chain, one exponent bit per stage
  logic [NS:0]           stg_valid;
  logic [NS:0]           stg_ready;
  gpi_pkg::word_t [NS:0] stg_data;

  assign stg_valid[0] = dec_valid;
  assign stg_data[0]  = dec_data;
  assign dec_ready    = stg_ready[0];

  for (genvar i = 0; i < NS; i++) begin : g_stage
    gpi_sqmul u_sqmul (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (stg_valid[i]),
      .in_ready  (stg_ready[i]),
      .in_data   (stg_data[i]),
      .out_valid (stg_valid[i+1]),
      .out_ready (stg_ready[i+1]),
      .out_data  (stg_data[i+1])
    );
  end

  assign stg_ready[NS] = m_axis_tready;
  assign m_axis_tvalid = stg_valid[NS];
  assign m_axis_tdata  = stg_data[NS].acc;

  // All exponent bits are used up by the last stage.
  a_expo_done: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (stg_data[NS].expo == gpi_pkg::FIELD_ZERO))
    else $error("exponent not fully consumed at output");

  // Reset empties the pipe.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> (!m_axis_tvalid && !dec_valid))
    else $error("valid bit survived reset");

  // A full decode stage that cannot move keeps its item.
  a_dec_hold: assert property (@(posedge clk) disable iff (rst)
    (dec_valid && !dec_ready) |=> (dec_valid && $stable(dec_data)))
    else $error("decode stage lost a stalled item");

  // Input is refused only when the output side is holding a result.
  a_ready_cause: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
    else $error("input stalled with room in the pipe");

endmodule

### tb/testbench.sv
// Self-checking stream testbench for the GF(2^8) multiply, power and inverse unit.
`timescale 1ns / 1ps

module testbench;

  // Code with no operation behind it; the unit answers it with zero.
  localparam logic [1:0] MODE_NONE = 2'd3;

  // Pipe depth from the top-level notes: decode register plus eight stages.
  localparam int PIPE_LATENCY = 9;

  // Random items, drain index, hold-off start (in accepted transfers), hold-off length.
  localparam int RANDOM_ITEMS  = 1330;
  localparam int DRAIN_AT      = 700;
  localparam int BACKLOG_AT    = 400;
  localparam int BACKLOG_HOLD  = 80;

  // One pending input transfer plus driver hints.
  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] operand_a;
    logic [7:0] operand_b;
    logic       tight;   // send with no idle gap after it
    logic       drain;   // wait for every result before sending it
  } op_item_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;   // [1:0] mode, [9:2] operand_a, [17:10] operand_b
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;        // [7:0] field_result

  op_item_t    pending_ops[$];
  logic [7:0]  results_due[$];

  int unsigned err_count = 0;
  int unsigned in_count = 0;
  int unsigned send_gap = 0;
  int unsigned recv_gap = 0;
  int unsigned backlog_left = 0;
  int unsigned rx_cycle = 0;
  bit          backlog_done = 1'b0;
  logic        in_xfer = 1'b0;
  op_item_t    next_op;
  logic [7:0]  want;

  gf256_mul_pow_inv i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------
  // Field arithmetic for the prediction
  // ---------------------------------------------------------------------

  // Shift-and-add product; a carry out of bit 7 folds back as 0x1B.
  function automatic logic [7:0] gf_product(input logic [7:0] x, input logic [7:0] y);
    logic [7:0] sum;
    logic [7:0] term;
    sum  = 8'h00;
    term = x;
    for (int i = 0; i < 8; i++) begin
      if (y[i]) begin
        sum ^= term;
      end
      term = term[7] ? ({term[6:0], 1'b0} ^ 8'h1B) : {term[6:0], 1'b0};
    end
    return sum;
  endfunction

  // Square-and-multiply from the exponent LSB; anything^0 is one.
  function automatic logic [7:0] gf_power(input logic [7:0] x, input logic [7:0] e);
    logic [7:0] run;
    logic [7:0] sq;
    run = 8'h01;
    sq  = x;
    for (int i = 0; i < 8; i++) begin
      if (e[i]) begin
        run = gf_product(run, sq);
      end
      sq = gf_product(sq, sq);
    end
    return run;
  endfunction

  function automatic logic [7:0] field_expected(input logic [1:0] mode,
                                                input logic [7:0] a,
                                                input logic [7:0] b);
    case (mode)
      gpi_pkg::MODE_MUL: return gf_product(a, b);
      gpi_pkg::MODE_POW: return gf_power(a, b);
      gpi_pkg::MODE_INV: return gf_power(a, 8'hFE);   // zero stays zero
      default:           return 8'h00;
    endcase
  endfunction

  // ---------------------------------------------------------------------
  // Random helpers
  // ---------------------------------------------------------------------

  // Operand bytes lean on the edges: zero, one and all ones.
  function automatic logic [7:0] pick_byte();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 10) return 8'h00;
    if (r < 20) return 8'hFF;
    if (r < 25) return 8'h01;
    return 8'($urandom);
  endfunction

  // Mostly back to back, some short gaps, a few long ones.
  function automatic int unsigned pick_gap(input bit tight);
    int unsigned r;
    if (tight) return 0;
    r = $urandom_range(99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(3, 1);
    return $urandom_range(30, 8);
  endfunction

  function automatic op_item_t make_op(input logic [1:0] mode, input logic [7:0] a,
                                       input logic [7:0] b, input logic drain);
    op_item_t it;
    it.mode      = mode;
    it.operand_a = a;
    it.operand_b = b;
    it.tight     = 1'b0;
    it.drain     = drain;
    return it;
  endfunction

  // ---------------------------------------------------------------------
  // Input driver: changes at the falling edge, one item per transfer
  // ---------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      send_gap      <= 0;
    end else if (!s_axis_tvalid || in_xfer) begin
      // Slot is free: either idle or the last item just transferred.
      if (send_gap > 0) begin
        s_axis_tvalid <= 1'b0;
        send_gap      <= send_gap - 1;
      end else if (pending_ops.size() == 0) begin
        s_axis_tvalid <= 1'b0;
      end else if (pending_ops[0].drain && results_due.size() != 0) begin
        // Sender pause: let the pipe run dry first.
        s_axis_tvalid <= 1'b0;
      end else begin
        next_op       = pending_ops.pop_front();
        s_axis_tdata  <= {6'b0, next_op.operand_b, next_op.operand_a, next_op.mode};
        s_axis_tvalid <= 1'b1;
        send_gap      <= pick_gap(next_op.tight);
      end
    end
  end

  // ---------------------------------------------------------------------
  // Output ready: random stalls, one long hold-off to back up the pipe
  // ---------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
      recv_gap      <= 0;
      rx_cycle      <= 0;
    end else begin
      rx_cycle <= rx_cycle + 1;
      if (backlog_left > 0) begin
        m_axis_tready <= 1'b0;
        backlog_left  <= backlog_left - 1;
      end else if (!backlog_done && in_count >= BACKLOG_AT) begin
        // Long hold-off, counted here, while the driver keeps offering.
        m_axis_tready <= 1'b0;
        backlog_left  <= BACKLOG_HOLD;
        backlog_done  <= 1'b1;
      end else if (recv_gap > 0) begin
        m_axis_tready <= 1'b0;
        recv_gap      <= recv_gap - 1;
      end else begin
        m_axis_tready <= 1'b1;
        // In one rx_cycle window out of every four, no random stall gaps are drawn.
        recv_gap      <= pick_gap((rx_cycle / 300) % 4 == 1);
      end
    end
  end

  // ---------------------------------------------------------------------
  // Monitor: sampled at the rising edge
  // ---------------------------------------------------------------------
  task automatic note_error(input bit stray, input logic [7:0] exp_v, input logic [7:0] act_v);
    err_count++;
    if (err_count <= 10) begin
      if (stray) begin
        $display("%0t: result transfer 0x%02h with nothing expected", $realtime, act_v);
      end else begin
        $display("%0t: field_result mismatch, expected 0x%02h got 0x%02h",
                 $realtime, exp_v, act_v);
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      in_xfer <= 1'b0;
    end else begin
      in_xfer <= s_axis_tvalid && s_axis_tready;
      // Retire before queuing, so a stray result never eats a fresh entry.
      if (m_axis_tvalid && m_axis_tready) begin
        if (results_due.size() == 0) begin
          note_error(1'b1, 8'h00, m_axis_tdata);
        end else begin
          want = results_due.pop_front();
          if (m_axis_tdata !== want) begin
            note_error(1'b0, want, m_axis_tdata);
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        results_due.push_back(field_expected(s_axis_tdata[1:0], s_axis_tdata[9:2],
                                             s_axis_tdata[17:10]));
        in_count <= in_count + 1;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus and end of run
  // ---------------------------------------------------------------------
  initial begin
    op_item_t it;
    int unsigned r;

    // Directed: edges of both bytes, every mode, zero exponent,
    // inverse of zero and the unused mode code.
    pending_ops.push_back(make_op(gpi_pkg::MODE_MUL, 8'h00, 8'h00, 1'b0));
    pending_ops.push_back(make_op(gpi_pkg::MODE_MUL, 8'hFF, 8'hFF, 1'b0));
    pending_ops.push_back(make_op(gpi_pkg::MODE_MUL, 8'h01, 8'hA5, 1'b0));
    pending_ops.push_back(make_op(gpi_pkg::MODE_MUL, 8'h57, 8'h83, 1'b0));
    pending_ops.push_back(make_op(gpi_pkg::MODE_MUL, 8'h80, 8'h02, 1'b0));
    pending_ops.push_back(make_op(gpi_pkg::MODE_MUL, 8'hFF, 8'h00, 1'b0));
    pending_ops.push_back(make_op(gpi_pkg::MODE_POW, 8'h00, 8'h00, 1'b0));
    pending_ops.push_back(make_op(gpi_pkg::MODE_POW, 8'hFF, 8'h00, 1'b0));
    pending_ops.push_back(make_op(gpi_pkg::MODE_POW, 8'h00, 8'h05, 1'b0));
    pending_ops.push_back(make_op(gpi_pkg::MODE_POW, 8'h02, 8'hFF, 1'b0));
    pending_ops.push_back(make_op(gpi_pkg::MODE_POW, 8'hFF, 8'hFF, 1'b0));
    pending_ops.push_back(make_op(gpi_pkg::MODE_POW, 8'h03, 8'h01, 1'b0));
    pending_ops.push_back(make_op(gpi_pkg::MODE_POW, 8'h03, 8'h80, 1'b0));
    pending_ops.push_back(make_op(gpi_pkg::MODE_INV, 8'h00, 8'h00, 1'b0));
    pending_ops.push_back(make_op(gpi_pkg::MODE_INV, 8'h01, 8'hFF, 1'b0));
    pending_ops.push_back(make_op(gpi_pkg::MODE_INV, 8'h53, 8'h00, 1'b0));
    pending_ops.push_back(make_op(gpi_pkg::MODE_INV, 8'hFF, 8'hFF, 1'b0));
    pending_ops.push_back(make_op(gpi_pkg::MODE_INV, 8'h02, 8'hAA, 1'b0));
    pending_ops.push_back(make_op(MODE_NONE, 8'hFF, 8'hFF, 1'b0));
    pending_ops.push_back(make_op(MODE_NONE, 8'h00, 8'h00, 1'b0));

    // Random: mostly real operations, a few unused codes; some stretches
    // go back to back, including the one around the long hold-off.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      r = $urandom_range(99);
      if (r < 5) begin
        it.mode = MODE_NONE;
      end else begin
        it.mode = 2'($urandom_range(2));
      end
      it.operand_a = pick_byte();
      it.operand_b = pick_byte();
      it.tight     = ((n / 150) % 3 == 2) || (n >= BACKLOG_AT - 40 && n < BACKLOG_AT + 120);
      it.drain     = (n == 0) || (n == DRAIN_AT);
      pending_ops.push_back(it);
    end

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (pending_ops.size() != 0 || s_axis_tvalid) @(posedge clk);
    while (results_due.size() != 0) @(posedge clk);
    // Watch a while longer for anything stray.
    repeat (4 * PIPE_LATENCY) @(posedge clk);

    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Watchdog, well past the slowest legal run.
  initial begin
    #5_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

### sim.f
hw/rtl/gpi_pkg.sv
hw/rtl/gpi_sqmul.sv
hw/rtl/gf256_mul_pow_inv.sv
tb/testbench.sv
